>>> src/cfs_pkg.sv
// Shared types and codes for the circular FIFO with search.
package cfs_pkg;

   localparam logic [2:0] MODE_PUSH   = 3'd0;
   localparam logic [2:0] MODE_POP    = 3'd1;
   localparam logic [2:0] MODE_PEEK   = 3'd2;
   localparam logic [2:0] MODE_SEARCH = 3'd3;
   localparam logic [2:0] MODE_CLEAR  = 3'd4;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_FULL  = 2'd1;
   localparam logic [1:0] STATUS_EMPTY = 2'd2;

   localparam int CAP_W  = 5;
   localparam int WORD_W = 32;

   typedef struct packed {
      logic [2:0]               mode;
      logic signed [WORD_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic signed [WORD_W-1:0] read_value;
      logic                     found;
      logic [1:0]               status;
      logic [CAP_W-1:0]         fill_level;
      logic                     is_empty;
      logic                     is_full;
   } rsp_type;

endpackage

>>> src/cfs_mem.sv
// Word storage of the FIFO: one write port, one read port with registered data.
module cfs_mem #(
   parameter int DEPTH  = 16,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic                               clock,
   input  logic                               wr_en,
   input  logic [ADDR_W-1:0]                  wr_addr,
   input  logic signed [cfs_pkg::WORD_W-1:0]  wr_data,
   input  logic                               rd_en,
   input  logic [ADDR_W-1:0]                  rd_addr,
   output logic signed [cfs_pkg::WORD_W-1:0]  rd_data
);
   import cfs_pkg::*;

   logic signed [WORD_W-1:0] mem [DEPTH];
   logic signed [WORD_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> src/circular_fifo_with_search.sv
// Circular FIFO of signed words with push, pop, peek, search and clear.
// Push, clear, rejected and unused operations: result registered in the cycle after accept, busy stays low.
// Pop and peek: one memory read; busy holds in ST_READ, then the result is registered from the read data.
// Search: the memory read port fetches one occupied entry per cycle from the head; busy lasts
// until a match or the last of up to fill_level (at most 16) entries; the result is then registered.
// Synchronous reset empties the queue and sets capacity to min(DEPTH, 16); storage is not cleared.
module circular_fifo_with_search #(
   parameter int DEPTH = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  cfs_pkg::req_type              req_data,
   output logic                          rsp_strobe,
   output cfs_pkg::rsp_type              rsp_data,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [cfs_pkg::CAP_W-1:0]     csr_data
);
   import cfs_pkg::*;

   localparam int CAP_MAX_INT = (DEPTH < 16) ? DEPTH : 16;
   localparam logic [CAP_W-1:0] CAP_MAX = CAP_W'(CAP_MAX_INT);
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int PTR_W  = $clog2(CAP_MAX_INT);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_READ   = 2'd1;
   localparam logic [1:0] ST_SEARCH = 2'd2;

   logic [1:0]             state_ff, state_in;
   logic [CAP_W-1:0]       cap_ff, cap_in;
   logic [CAP_W-1:0]       count_ff, count_in;
   logic [PTR_W-1:0]       rptr_ff, rptr_in;
   logic [PTR_W-1:0]       wptr_ff, wptr_in;
   logic [PTR_W-1:0]       scan_ff, scan_in;
   logic [CAP_W-1:0]       left_ff, left_in;
   logic signed [WORD_W-1:0] value_ff, value_in;
   logic                   rsp_strobe_ff, rsp_strobe_in;
   rsp_type                rsp_ff, rsp_in;

   logic                   wr_en;
   logic                   rd_en;
   logic [PTR_W-1:0]       rd_ptr;
   logic signed [WORD_W-1:0] rd_data;

   logic                   accept;
   logic                   csr_write;

   function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p,
                                                input logic [CAP_W-1:0] cap);
      logic [CAP_W:0] n;
      n = (CAP_W+1)'(p) + (CAP_W+1)'(1);
      return (n >= {1'b0, cap}) ? '0 : PTR_W'(n);
   endfunction

   cfs_mem #(
      .DEPTH  (DEPTH),
      .ADDR_W (ADDR_W)
   ) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (ADDR_W'(wptr_ff)),
      .wr_data (req_data.value),
      .rd_en   (rd_en),
      .rd_addr (ADDR_W'(rd_ptr)),
      .rd_data (rd_data)
   );

   assign busy      = (state_ff != ST_IDLE);
   // A capacity write is held off while a transaction is offered, so the two never meet.
   assign csr_ready = ~busy & ~start;
   assign accept    = start & ~busy;
   assign csr_write = csr_valid & csr_ready;

   always_comb begin
      logic signed [WORD_W-1:0] rd_val;
      logic                     hit;
      logic [1:0]               status_v;
      logic                     match;

      state_in      = state_ff;
      cap_in        = cap_ff;
      count_in      = count_ff;
      rptr_in       = rptr_ff;
      wptr_in       = wptr_ff;
      scan_in       = scan_ff;
      left_in       = left_ff;
      value_in      = value_ff;
      rsp_strobe_in = 1'b0;
      wr_en         = 1'b0;
      rd_en         = 1'b0;
      rd_ptr        = rptr_ff;
      rd_val        = '0;
      hit           = 1'b0;
      status_v      = STATUS_OK;
      match         = (rd_data == value_ff);

      // Capacity changes only on an empty queue and only to a legal value.
      if (csr_write && count_ff == '0 && csr_data != '0 && csr_data <= CAP_MAX) begin
         cap_in  = csr_data;
         rptr_in = '0;
         wptr_in = '0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               value_in = req_data.value;
               unique case (req_data.mode) inside
                  MODE_PUSH: begin
                     rsp_strobe_in = 1'b1;
                     if (count_ff >= cap_ff) begin
                        status_v = STATUS_FULL;
                     end else begin
                        wr_en    = 1'b1;
                        wptr_in  = next_ptr(wptr_ff, cap_ff);
                        count_in = count_ff + CAP_W'(1);
                     end
                  end
                  MODE_POP, MODE_PEEK: begin
                     if (count_ff == '0) begin
                        rsp_strobe_in = 1'b1;
                        status_v      = STATUS_EMPTY;
                     end else begin
                        rd_en    = 1'b1;
                        state_in = ST_READ;
                        if (req_data.mode == MODE_POP) begin
                           rptr_in  = next_ptr(rptr_ff, cap_ff);
                           count_in = count_ff - CAP_W'(1);
                        end
                     end
                  end
                  MODE_SEARCH: begin
                     if (count_ff == '0) begin
                        rsp_strobe_in = 1'b1;
                     end else begin
                        rd_en    = 1'b1;
                        scan_in  = next_ptr(rptr_ff, cap_ff);
                        left_in  = count_ff - CAP_W'(1);
                        state_in = ST_SEARCH;
                     end
                  end
                  MODE_CLEAR: begin
                     rsp_strobe_in = 1'b1;
                     count_in      = '0;
                     rptr_in       = wptr_ff;
                  end
                  default: begin
                     rsp_strobe_in = 1'b1;
                  end
               endcase
            end
         end
         ST_READ: begin
            rsp_strobe_in = 1'b1;
            rd_val        = rd_data;
            state_in      = ST_IDLE;
         end
         ST_SEARCH: begin
            // Compare the entry read last cycle while the next one is fetched.
            if (match || left_ff == '0) begin
               rsp_strobe_in = 1'b1;
               hit           = match;
               state_in      = ST_IDLE;
            end else begin
               rd_en   = 1'b1;
               rd_ptr  = scan_ff;
               scan_in = next_ptr(scan_ff, cap_ff);
               left_in = left_ff - CAP_W'(1);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rsp_in = rsp_ff;
      if (rsp_strobe_in) begin
         rsp_in.read_value = rd_val;
         rsp_in.found      = hit;
         rsp_in.status     = status_v;
         rsp_in.fill_level = count_in;
         rsp_in.is_empty   = (count_in == '0);
         rsp_in.is_full    = (count_in == cap_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         cap_ff        <= CAP_MAX;
         count_ff      <= '0;
         rptr_ff       <= '0;
         wptr_ff       <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cap_ff        <= cap_in;
         count_ff      <= count_in;
         rptr_ff       <= rptr_in;
         wptr_ff       <= wptr_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_ff  <= scan_in;
      left_ff  <= left_in;
      value_ff <= value_in;
      rsp_ff   <= rsp_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

   a_count_in_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= cap_ff)
      else $error("fill count exceeds capacity");

   a_search_nonempty: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SEARCH |-> count_ff != '0 && left_ff < count_ff)
      else $error("search running over an empty queue");

   a_busy_no_strobe: assert property (@(posedge clock) disable iff (reset)
      $rose(busy) |-> !rsp_strobe_ff)
      else $error("transaction answered while its memory read is pending");

   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      accept && req_data.mode == MODE_PUSH && count_ff < cap_ff && !csr_write
      |=> count_ff == $past(count_ff) + CAP_W'(1))
      else $error("accepted push did not grow the queue");

endmodule

>>> tb/sv/testbench.sv
// Self-checking testbench for the circular FIFO with search.
`timescale 1ns / 1ps

module testbench;
   import cfs_pkg::*;

   localparam int FIFO_DEPTH = 16;
   localparam int STALL_LIMIT = 1000;
   localparam int PRINT_LIMIT = 40;
   localparam int PHASE_COUNT = 10;
   localparam int PHASE_ITEMS = 110;
   // Modes without an operation; the block must answer them as a no-op.
   localparam logic [2:0] MODE_SPARE_FIRST = 3'd5;
   localparam logic [2:0] MODE_SPARE_LAST  = 3'd7;

   logic             clock;
   logic             reset = 1'b1;
   logic             start = 1'b0;
   logic             busy;
   req_type          req = '0;
   logic             rsp_strobe;
   rsp_type          rsp;
   logic             csr_valid = 1'b0;
   logic             csr_ready;
   logic [CAP_W-1:0] csr_data = '0;

   class fifo_scoreboard;
      logic [WORD_W-1:0] slots [FIFO_DEPTH];
      int                capacity;
      int                head;
      int                tail;
      int                occupied;
      rsp_type           awaited [$];
      int                failures;

      function new();
         capacity = (FIFO_DEPTH < 16) ? FIFO_DEPTH : 16;
         head = 0;
         tail = 0;
         occupied = 0;
         failures = 0;
      endfunction

      function int step_slot(int idx);
         return (idx + 1 >= capacity) ? 0 : idx + 1;
      endfunction

      // A capacity write only lands on an empty queue with a legal value.
      function void apply_capacity(logic [CAP_W-1:0] data);
         if (occupied != 0 || data == 0 || data > FIFO_DEPTH)
            return;
         capacity = int'(data);
         head = 0;
         tail = 0;
      endfunction

      function void note_request(req_type item);
         rsp_type outcome;
         int      idx;
         int      k;
         outcome = '0;
         outcome.status = STATUS_OK;
         case (item.mode) inside
            MODE_PUSH: begin
               if (occupied >= capacity) begin
                  outcome.status = STATUS_FULL;
               end else begin
                  slots[tail] = item.value;
                  tail = step_slot(tail);
                  occupied++;
               end
            end
            MODE_POP, MODE_PEEK: begin
               if (occupied == 0) begin
                  outcome.status = STATUS_EMPTY;
               end else begin
                  outcome.read_value = slots[head];
                  if (item.mode == MODE_POP) begin
                     head = step_slot(head);
                     occupied--;
                  end
               end
            end
            MODE_SEARCH: begin
               idx = head;
               for (k = 0; k < occupied; k++) begin
                  if (slots[idx] == item.value) begin
                     outcome.found = 1'b1;
                     break;
                  end
                  idx = step_slot(idx);
               end
            end
            MODE_CLEAR: begin
               occupied = 0;
               head = tail;
            end
            default: ;
         endcase
         outcome.fill_level = CAP_W'(occupied);
         outcome.is_empty = (occupied == 0);
         outcome.is_full = (occupied == capacity);
         awaited.push_back(outcome);
      endfunction

      task report_mismatch(string what);
         if (failures < PRINT_LIMIT)
            $display("[%0t] ERROR: %s", $time, what);
         failures++;
      endtask

      task compare_field(string name, logic [WORD_W-1:0] got, logic [WORD_W-1:0] want);
         if (got !== want)
            report_mismatch($sformatf("%s: got 0x%h, want 0x%h", name, got, want));
      endtask

      task check_response(rsp_type got);
         rsp_type want;
         if (awaited.size() == 0) begin
            report_mismatch("result strobe with no transaction outstanding");
            return;
         end
         want = awaited.pop_front();
         compare_field("read_value", got.read_value, want.read_value);
         compare_field("found", WORD_W'(got.found), WORD_W'(want.found));
         compare_field("status", WORD_W'(got.status), WORD_W'(want.status));
         compare_field("fill_level", WORD_W'(got.fill_level), WORD_W'(want.fill_level));
         compare_field("is_empty", WORD_W'(got.is_empty), WORD_W'(want.is_empty));
         compare_field("is_full", WORD_W'(got.is_full), WORD_W'(want.is_full));
      endtask

      task check_drained();
         if (awaited.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", awaited.size()));
      endtask
   endclass

   fifo_scoreboard sb = new();

   int                idle_pct = 0;
   int                quiet_cycles = 0;
   logic [WORD_W-1:0] word_pool [8];

   circular_fifo_with_search #(
      .DEPTH(FIFO_DEPTH)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Monitor: everything is sampled at the rising edge, before the block updates.
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready)
            sb.apply_capacity(csr_data);
         if (start && !busy)
            sb.note_request(req);
         if (rsp_strobe)
            sb.check_response(rsp);
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe || (csr_valid && csr_ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("circular_fifo_with_search: mismatch");
            $finish;
         end
      end
   end

   task automatic send_item(logic [2:0] mode, logic [WORD_W-1:0] value);
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req <= '{mode: mode, value: value};
      do
         @(posedge clock);
      while (busy);
   endtask

   // The first edge lets the monitor record the last accepted transaction.
   task automatic wait_drained();
      start <= 1'b0;
      @(posedge clock);
      while (sb.awaited.size() != 0)
         @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_capacity(logic [CAP_W-1:0] data);
      wait_drained();
      csr_valid <= 1'b1;
      csr_data <= data;
      do
         @(posedge clock);
      while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [WORD_W-1:0] pick_word();
      int pick;
      pick = $urandom_range(9);
      if (pick < 5)
         return word_pool[$urandom_range(7)];
      if (pick == 5)
         return $urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
      return $urandom();
   endfunction

   task automatic random_burst(int count);
      int push_pct;
      int roll;
      for (int n = 0; n < count; n++) begin
         // Tilt the mix every 24 transactions so the queue drifts full and empty.
         if (n % 24 == 0)
            push_pct = $urandom_range(60, 20);
         if ($urandom_range(99) < push_pct) begin
            send_item(MODE_PUSH, pick_word());
         end else begin
            roll = $urandom_range(99);
            if (roll < 38)
               send_item(MODE_POP, pick_word());
            else if (roll < 55)
               send_item(MODE_PEEK, pick_word());
            else if (roll < 90)
               send_item(MODE_SEARCH, pick_word());
            else if (roll < 96)
               send_item(MODE_CLEAR, pick_word());
            else
               send_item(3'($urandom_range(MODE_SPARE_LAST, MODE_SPARE_FIRST)), $urandom());
         end
      end
   endtask

   initial begin
      int phase_caps [PHASE_COUNT];
      int phase_idle [PHASE_COUNT];
      phase_caps = '{16, 1, 2, 3, 7, 16, 4, 1, 9, 16};
      phase_idle = '{0, 86, 33, 0, 86, 33, 0, 86, 33, 0};

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: empty-queue errors, spare modes, extreme words, search hits and misses.
      send_item(MODE_POP, 32'h0);
      send_item(MODE_PEEK, 32'hFFFF_FFFF);
      send_item(MODE_SEARCH, 32'h0);
      send_item(MODE_SPARE_LAST, 32'hFFFF_FFFF);
      send_item(MODE_PUSH, 32'h7FFF_FFFF);
      send_item(MODE_PUSH, 32'h8000_0000);
      send_item(MODE_PUSH, 32'hFFFF_FFFF);
      send_item(MODE_PUSH, 32'h0);
      send_item(MODE_PEEK, 32'h0);
      send_item(MODE_SEARCH, 32'h8000_0000);
      send_item(MODE_SEARCH, 32'h1234_5678);
      send_item(MODE_POP, 32'h0);
      send_item(MODE_SPARE_FIRST, 32'h0);
      // The queue still holds words, so this capacity write must be dropped.
      write_capacity(5'd5);
      send_item(MODE_CLEAR, 32'h0);
      send_item(MODE_POP, 32'h0);
      write_capacity(5'd0);
      write_capacity(5'd31);
      write_capacity(5'd17);
      write_capacity(5'd1);
      send_item(MODE_PUSH, 32'hA5A5_A5A5);
      send_item(MODE_PUSH, 32'h5A5A_5A5A);
      send_item(MODE_SEARCH, 32'h5A5A_5A5A);
      send_item(MODE_POP, 32'h0);
      // With three entries the search has to wrap past the last slot.
      write_capacity(5'd3);
      send_item(MODE_PUSH, 32'h0000_0011);
      send_item(MODE_PUSH, 32'h0000_0022);
      send_item(MODE_PUSH, 32'h0000_0033);
      send_item(MODE_POP, 32'h0);
      send_item(MODE_PUSH, 32'h0000_0044);
      send_item(MODE_SEARCH, 32'h0000_0044);
      send_item(MODE_SEARCH, 32'h0000_0011);
      send_item(MODE_CLEAR, 32'h0);

      for (int p = 0; p < PHASE_COUNT; p++) begin
         foreach (word_pool[i])
            word_pool[i] = $urandom();
         // Some phases try a write before clearing, which may meet a non-empty queue and be dropped.
         if (p % 3 == 1) begin
            write_capacity(5'(phase_caps[p]));
            write_capacity($urandom_range(1) ? 5'd0 : 5'($urandom_range(31, 17)));
         end
         idle_pct = 0;
         send_item(MODE_CLEAR, $urandom());
         write_capacity(5'(phase_caps[p]));
         idle_pct = phase_idle[p];
         random_burst(PHASE_ITEMS);
      end

      wait_drained();
      repeat (20) @(posedge clock);
      sb.check_drained();
      if (sb.failures == 0)
         $display("circular_fifo_with_search: match");
      else
         $display("circular_fifo_with_search: mismatch");
      $finish;
   end

endmodule

>>> circular_fifo_with_search.f
src/cfs_pkg.sv
src/cfs_mem.sv
src/circular_fifo_with_search.sv
tb/sv/testbench.sv
